>>> sv/priority_drop_record_buffer_macros.svh
// Assertion macros shared by the record buffer checker.
// Depends on nothing; included by pdrb_chk.sv.
`ifndef PRIORITY_DROP_RECORD_BUFFER_MACROS_SVH
`define PRIORITY_DROP_RECORD_BUFFER_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define PDRB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define PDRB_ASSERT_RST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/pdrb_pkg.sv
// Types and constants of the priority drop record buffer.
// Depends on nothing; used by every module of the block.
package pdrb_pkg;

   localparam int SIZE_W = 10;

   // Header bytes plus the two terminators.
   localparam logic [SIZE_W-1:0] REC_OVERHEAD = 10'd6;

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   localparam logic [1:0] KIND_MEASUREMENT = 2'd0;

   localparam logic [2:0] STAT_STORED    = 3'd0;
   localparam logic [2:0] STAT_TOO_LARGE = 3'd1;
   localparam logic [2:0] STAT_NO_ROOM   = 3'd2;
   localparam logic [2:0] STAT_POPPED    = 3'd3;
   localparam logic [2:0] STAT_EMPTY     = 3'd4;

   typedef struct packed {
      logic        mode;
      logic [1:0]  record_kind;
      logic [7:0]  type_length;
      logic [7:0]  payload_length;
      logic [15:0] record_tag;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  drops_this_step;
      logic [31:0] dropped_total;
      logic [10:0] bytes_used;
      logic [8:0]  record_count;
      logic        front_valid;
      logic [1:0]  front_kind;
      logic [15:0] front_tag;
      logic [10:0] front_size;
   } rsp_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [15:0]       tag;
      logic [SIZE_W-1:0] size;
   } entry_type;

endpackage

>>> sv/pdrb_mem.sv
// Record descriptor store: one shared address, registered read data.
// Depends on pdrb_pkg for the entry type.
module pdrb_mem #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic                clock,
   input  logic                we,
   input  logic                re,
   input  logic [AW-1:0]       addr,
   input  pdrb_pkg::entry_type wdata,
   output pdrb_pkg::entry_type rdata
);
   import pdrb_pkg::*;

   entry_type table_ff [DEPTH];
   entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         table_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= table_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/pdrb_seq.sv
// Sequencer and counters of the record buffer: push, pop, drop scan and compaction.
// Depends on pdrb_pkg; drives the descriptor store in pdrb_mem.
module pdrb_seq #(
   parameter int BUFFER_BYTES = 1024,
   parameter int MAX_RECORDS  = 256,
   parameter int AW           = 8
) (
   input  logic                clock,
   input  logic                reset,
   output logic                idle,
   input  logic                req_go,
   input  pdrb_pkg::req_type   req,
   output logic                mem_we,
   output logic                mem_re,
   output logic [AW-1:0]       mem_addr,
   output pdrb_pkg::entry_type mem_wdata,
   input  pdrb_pkg::entry_type mem_rdata,
   output logic                res_done,
   input  logic                res_take,
   output pdrb_pkg::rsp_type   res
);
   import pdrb_pkg::*;

   localparam int CW = $clog2(MAX_RECORDS + 1);
   localparam int BW = $clog2(BUFFER_BYTES + 1);
   localparam int NW = ((BW > SIZE_W) ? BW : SIZE_W) + 1;
   localparam int SW = CW + 1;
   localparam int BX = (BW > 11) ? BW : 11;
   localparam int CX = (CW > 9) ? CW : 9;

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b000_0000_0001,
      ST_POP      = 11'b000_0000_0010,
      ST_PUSH     = 11'b000_0000_0100,
      ST_CHECK    = 11'b000_0000_1000,
      ST_SCAN_RD  = 11'b000_0001_0000,
      ST_SCAN_CHK = 11'b000_0010_0000,
      ST_SHIFT_RD = 11'b000_0100_0000,
      ST_SHIFT_WR = 11'b000_1000_0000,
      ST_FRONT_RD = 11'b001_0000_0000,
      ST_FRONT_WR = 11'b010_0000_0000,
      ST_DONE     = 11'b100_0000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [BW-1:0]     bytes_ff, bytes_in;
   logic [31:0]       total_ff, total_in;
   logic [7:0]        drops_ff, drops_in;
   logic [2:0]        status_ff, status_in;
   logic [CW-1:0]     scan_ff, scan_in;
   logic [CW-1:0]     move_ff, move_in;
   logic [1:0]        kind_ff, kind_in;
   logic [15:0]       tag_ff, tag_in;
   logic [SIZE_W-1:0] need_ff, need_in;
   logic              mode_ff, mode_in;
   entry_type         front_ff, front_in;
   logic              fvalid_ff, fvalid_in;

   logic [CW-1:0]     offset;
   logic [SW-1:0]     addr_sum;
   logic [AW-1:0]     addr_wrap;
   logic [CW-1:0]     move_next;
   logic              fits;
   logic              too_large;
   logic [BX-1:0]     bytes_x;
   logic [CX-1:0]     count_x;

   // The shared address unit: head plus an offset, wrapped once around the ring.
   always_comb begin
      unique case (state_ff)
         ST_POP:      offset = CW'(1);
         ST_CHECK:    offset = count_ff;
         ST_SCAN_RD:  offset = scan_ff;
         ST_SHIFT_RD: offset = move_next;
         ST_SHIFT_WR: offset = move_ff;
         default:     offset = '0;
      endcase
      addr_sum = SW'(head_ff) + SW'(offset);
      if (addr_sum >= SW'(MAX_RECORDS)) begin
         addr_wrap = AW'(addr_sum - SW'(MAX_RECORDS));
      end else begin
         addr_wrap = AW'(addr_sum);
      end
   end

   assign move_next = move_ff + CW'(1);
   assign fits      = (NW'(bytes_ff) + NW'(need_ff) <= NW'(BUFFER_BYTES)) &&
                      (count_ff < CW'(MAX_RECORDS));
   assign too_large = NW'(need_ff) > NW'(BUFFER_BYTES);

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      bytes_in  = bytes_ff;
      total_in  = total_ff;
      drops_in  = drops_ff;
      status_in = status_ff;
      scan_in   = scan_ff;
      move_in   = move_ff;
      kind_in   = kind_ff;
      tag_in    = tag_ff;
      need_in   = need_ff;
      mode_in   = mode_ff;
      front_in  = front_ff;
      fvalid_in = fvalid_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_wdata = mem_rdata;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_go) begin
               mode_in  = req.mode;
               kind_in  = req.record_kind;
               tag_in   = req.record_tag;
               need_in  = SIZE_W'(req.type_length) + SIZE_W'(req.payload_length) +
                          REC_OVERHEAD;
               drops_in = '0;
               scan_in  = '0;
               state_in = (req.mode == MODE_POP) ? ST_POP : ST_PUSH;
            end
         end
         ST_POP: begin
            if (count_ff == '0) begin
               status_in = STAT_EMPTY;
            end else begin
               head_in   = addr_wrap;
               count_in  = count_ff - CW'(1);
               bytes_in  = bytes_ff - BW'(front_ff.size);
               status_in = STAT_POPPED;
            end
            state_in = ST_FRONT_RD;
         end
         ST_PUSH: begin
            if (too_large) begin
               status_in = STAT_TOO_LARGE;
               state_in  = ST_FRONT_RD;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (fits) begin
               mem_we         = 1'b1;
               mem_wdata.kind = kind_ff;
               mem_wdata.tag  = tag_ff;
               mem_wdata.size = need_ff;
               count_in       = count_ff + CW'(1);
               bytes_in       = bytes_ff + BW'(need_ff);
               status_in      = STAT_STORED;
               state_in       = ST_FRONT_RD;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            // Records ahead of the scan position hold no measurement, so the
            // search resumes where the previous drop left off.
            if (scan_ff == count_ff) begin
               status_in = STAT_NO_ROOM;
               state_in  = ST_FRONT_RD;
            end else begin
               mem_re   = 1'b1;
               state_in = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (mem_rdata.kind == KIND_MEASUREMENT) begin
               bytes_in = bytes_ff - BW'(mem_rdata.size);
               total_in = total_ff + 32'd1;
               if (drops_ff != 8'hFF) begin
                  drops_in = drops_ff + 8'd1;
               end
               move_in  = scan_ff;
               state_in = ST_SHIFT_RD;
            end else begin
               scan_in  = scan_ff + CW'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_SHIFT_RD: begin
            if (move_next == count_ff) begin
               count_in = count_ff - CW'(1);
               state_in = ST_CHECK;
            end else begin
               mem_re   = 1'b1;
               state_in = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            mem_we   = 1'b1;
            move_in  = move_next;
            state_in = ST_SHIFT_RD;
         end
         ST_FRONT_RD: begin
            mem_re   = 1'b1;
            state_in = ST_FRONT_WR;
         end
         ST_FRONT_WR: begin
            fvalid_in = count_ff != '0;
            front_in  = (count_ff != '0) ? mem_rdata : '0;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         head_ff   <= '0;
         count_ff  <= '0;
         bytes_ff  <= '0;
         total_ff  <= '0;
         fvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         count_ff  <= count_in;
         bytes_ff  <= bytes_in;
         total_ff  <= total_in;
         fvalid_ff <= fvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      drops_ff  <= drops_in;
      status_ff <= status_in;
      scan_ff   <= scan_in;
      move_ff   <= move_in;
      kind_ff   <= kind_in;
      tag_ff    <= tag_in;
      need_ff   <= need_in;
      mode_ff   <= mode_in;
      front_ff  <= front_in;
   end

   assign mem_addr = addr_wrap;
   assign idle     = state_ff == ST_IDLE;
   assign res_done = state_ff == ST_DONE;
   assign bytes_x  = BX'(bytes_ff);
   assign count_x  = CX'(count_ff);

   always_comb begin
      res.status          = status_ff;
      res.drops_this_step = (mode_ff == MODE_PUSH) ? drops_ff : 8'd0;
      res.dropped_total   = total_ff;
      res.bytes_used      = bytes_x[10:0];
      res.record_count    = count_x[8:0];
      res.front_valid     = fvalid_ff;
      res.front_kind      = front_ff.kind;
      res.front_tag       = front_ff.tag;
      res.front_size      = 11'(front_ff.size);
   end

endmodule

>>> sv/priority_drop_record_buffer.sv
// Priority drop record buffer: a byte-budgeted queue of record descriptors in which
// a push that does not fit discards the oldest measurement records until it does,
// or is refused when no measurement is left. One item is handled at a time; req_stall
// is high from acceptance until the result has been placed in the output register.
// A pop or a refused oversize push passes through the pop or push state, a read of
// the new front record and its capture into the result, and then waits in the done
// state until the result is taken; a push that fits at once also passes through the
// room check before it is stored. To make room, the scan reads and then tests every
// record it examines; each dropped measurement then moves every later record down one
// slot with a read and a write, and a last read state and a fresh room check finish
// the move. A push refused for want of a measurement ends in the scan read state at
// the end of the queue. Every step goes through the single read/write port of the
// descriptor store. With the default sizes the queue holds at most 170 records. The
// output register lets the next item be accepted while a result waits to be taken.
// Depends on pdrb_pkg, pdrb_mem and pdrb_seq.
module priority_drop_record_buffer #(
   parameter int BUFFER_BYTES = 1024,
   parameter int MAX_RECORDS  = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pdrb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pdrb_pkg::rsp_type rsp_data
);
   import pdrb_pkg::*;

   localparam int AW = $clog2(MAX_RECORDS);

   logic          idle;
   logic          req_go;
   logic          mem_we;
   logic          mem_re;
   logic [AW-1:0] mem_addr;
   entry_type     mem_wdata;
   entry_type     mem_rdata;
   logic          res_done;
   logic          res_take;
   rsp_type       res;

   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff;

   assign req_stall = !idle;
   assign req_go    = req_valid && idle;
   assign res_take  = res_done && (!rsp_valid_ff || !rsp_stall);

   pdrb_mem #(
      .DEPTH (MAX_RECORDS),
      .AW    (AW)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   pdrb_seq #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .MAX_RECORDS  (MAX_RECORDS),
      .AW           (AW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .idle      (idle),
      .req_go    (req_go),
      .req       (req_data),
      .mem_we    (mem_we),
      .mem_re    (mem_re),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata),
      .res_done  (res_done),
      .res_take  (res_take),
      .res       (res)
   );

   always_comb begin
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> sv/pdrb_chk.sv
// Port checker of the priority drop record buffer, bound to the top level.
// Depends on pdrb_pkg and priority_drop_record_buffer_macros.svh.
`include "priority_drop_record_buffer_macros.svh"

module pdrb_chk (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input pdrb_pkg::rsp_type rsp_data
);
   import pdrb_pkg::*;

   // No result may be shown in the cycle after reset.
   `PDRB_ASSERT_RST(a_no_rsp_after_reset, clock, reset |=> !rsp_valid, "result valid after reset")

   // A stalled result stays put.
   `PDRB_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled result changed")

   // The block works on one item at a time.
   `PDRB_ASSERT(a_busy_after_accept, clock, reset, req_valid && !req_stall |=> req_stall, "second item taken while busy")

   // An empty buffer holds no bytes and shows a cleared front record.
   `PDRB_ASSERT(a_empty_front, clock, reset, rsp_valid && !rsp_data.front_valid |-> rsp_data.bytes_used == 11'd0 && rsp_data.front_size == 11'd0, "empty buffer reports bytes or a front size")

   // Only a push that had to make room can report drops.
   `PDRB_ASSERT(a_drops_status, clock, reset, rsp_valid && rsp_data.drops_this_step != 8'd0 |-> rsp_data.status == STAT_STORED || rsp_data.status == STAT_NO_ROOM, "drops reported for wrong status")

endmodule

bind priority_drop_record_buffer pdrb_chk u_pdrb_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> tb/priority_drop_record_buffer_tb.sv
// Self-checking testbench for the priority drop record buffer. It drives push and pop
// items, works out each result from its own model of the record queue and checks them.
// Depends on pdrb_pkg and priority_drop_record_buffer.
module priority_drop_record_buffer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pdrb_pkg::*;

   localparam int BUFFER_BYTES = 1024;
   localparam int MAX_RECORDS  = 256;
   localparam int QUIET_LIMIT  = 100000;
   localparam int LONG_HOLD    = 400;

   localparam logic [1:0] KIND_EVENT       = 2'd1;
   localparam logic [1:0] KIND_ALARM       = 2'd2;
   localparam logic [1:0] KIND_ALARM_CLEAR = 2'd3;

   typedef struct {
      logic [1:0]  kind;
      logic [15:0] tag;
      logic [10:0] size;
   } queued_record_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Model of the queue contents and counters, updated as each item is accepted.
   queued_record_type queued_records[$];
   int                queued_bytes = 0;
   logic [31:0]       discarded_total = '0;
   rsp_type           pending_results[$];

   int error_count        = 0;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_left          = 0;
   int quiet_cycles       = 0;

   priority_drop_record_buffer #(
      .BUFFER_BYTES(BUFFER_BYTES),
      .MAX_RECORDS (MAX_RECORDS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic rsp_type apply_to_queue(input req_type item);
      rsp_type           result;
      int                need;
      int                victim;
      queued_record_type rec;
      result = '0;
      if (item.mode == MODE_POP) begin
         if (queued_records.size() == 0) begin
            result.status = STAT_EMPTY;
         end else begin
            queued_bytes -= int'(queued_records[0].size);
            queued_records.delete(0);
            result.status = STAT_POPPED;
         end
      end else begin
         need = int'(REC_OVERHEAD) + int'(item.type_length) + int'(item.payload_length);
         if (need > BUFFER_BYTES) begin
            result.status = STAT_TOO_LARGE;
         end else begin
            result.status = STAT_STORED;
            while (queued_bytes + need > BUFFER_BYTES || queued_records.size() >= MAX_RECORDS)
            begin
               victim = -1;
               foreach (queued_records[i]) begin
                  if (victim < 0 && queued_records[i].kind == KIND_MEASUREMENT) victim = i;
               end
               if (victim < 0) begin
                  result.status = STAT_NO_ROOM;
                  break;
               end
               queued_bytes -= int'(queued_records[victim].size);
               queued_records.delete(victim);
               discarded_total++;
               if (result.drops_this_step != 8'hFF) result.drops_this_step++;
            end
            if (result.status == STAT_STORED) begin
               rec.kind = item.record_kind;
               rec.tag  = item.record_tag;
               rec.size = 11'(need);
               queued_records.push_back(rec);
               queued_bytes += need;
            end
         end
      end
      result.dropped_total = discarded_total;
      result.bytes_used    = 11'(queued_bytes);
      result.record_count  = 9'(queued_records.size());
      if (queued_records.size() > 0) begin
         result.front_valid = 1'b1;
         result.front_kind  = queued_records[0].kind;
         result.front_tag   = queued_records[0].tag;
         result.front_size  = queued_records[0].size;
      end
      return result;
   endfunction

   function automatic req_type make_item(input logic mode, input logic [1:0] kind,
                                         input logic [7:0] tlen, input logic [7:0] plen,
                                         input logic [15:0] tag);
      req_type item;
      item.mode           = mode;
      item.record_kind    = kind;
      item.type_length    = tlen;
      item.payload_length = plen;
      item.record_tag     = tag;
      return item;
   endfunction

   // Mostly short strings so that the queue holds many records; now and then any length.
   function automatic req_type random_item(input int push_pct, input int meas_pct);
      req_type item;
      item.mode        = ($urandom_range(99) < push_pct) ? MODE_PUSH : MODE_POP;
      item.record_kind = ($urandom_range(99) < meas_pct) ? KIND_MEASUREMENT
                                                         : 2'($urandom_range(3, 1));
      item.record_tag  = 16'($urandom());
      if ($urandom_range(9) == 0) begin
         item.type_length    = 8'($urandom());
         item.payload_length = 8'($urandom());
      end else begin
         item.type_length    = 8'($urandom_range(31));
         item.payload_length = 8'($urandom_range(31));
      end
      return item;
   endfunction

   task automatic send_item(input req_type item);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_results.push_back(apply_to_queue(item));
   endtask

   task automatic wait_all_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic report_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      error_count++;
   endtask

   task automatic check_result(input rsp_type want, input rsp_type got);
      if (got.status !== want.status)
         report_field("status", 32'(want.status), 32'(got.status));
      if (got.drops_this_step !== want.drops_this_step)
         report_field("drops_this_step", 32'(want.drops_this_step), 32'(got.drops_this_step));
      if (got.dropped_total !== want.dropped_total)
         report_field("dropped_total", want.dropped_total, got.dropped_total);
      if (got.bytes_used !== want.bytes_used)
         report_field("bytes_used", 32'(want.bytes_used), 32'(got.bytes_used));
      if (got.record_count !== want.record_count)
         report_field("record_count", 32'(want.record_count), 32'(got.record_count));
      if (got.front_valid !== want.front_valid)
         report_field("front_valid", 32'(want.front_valid), 32'(got.front_valid));
      if (got.front_kind !== want.front_kind)
         report_field("front_kind", 32'(want.front_kind), 32'(got.front_kind));
      if (got.front_tag !== want.front_tag)
         report_field("front_tag", 32'(want.front_tag), 32'(got.front_tag));
      if (got.front_size !== want.front_size)
         report_field("front_size", 32'(want.front_size), 32'(got.front_size));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %h", $time, rsp_data);
            error_count++;
         end else begin
            check_result(pending_results.pop_front(), rsp_data);
         end
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("priority_drop_record_buffer_tb failed");
         $finish;
      end
   end

   task automatic test_pop_on_empty();
      send_item(make_item(MODE_POP, KIND_ALARM_CLEAR, 8'hFF, 8'hFF, 16'hFFFF));
      send_item(make_item(MODE_POP, KIND_MEASUREMENT, 8'h00, 8'h00, 16'h0000));
   endtask

   task automatic test_kinds_and_extremes();
      send_item(make_item(MODE_PUSH, KIND_MEASUREMENT, 8'd0, 8'd0, 16'h0000));
      send_item(make_item(MODE_PUSH, KIND_EVENT, 8'd255, 8'd0, 16'hFFFF));
      send_item(make_item(MODE_PUSH, KIND_ALARM, 8'd0, 8'd255, 16'hA5A5));
      send_item(make_item(MODE_PUSH, KIND_ALARM_CLEAR, 8'd128, 8'd127, 16'h5A5A));
      repeat (5) send_item(random_item(0, 50));
   endtask

   // Two records of the largest size cannot both fit, so the second one pushes out
   // the measurement ahead of it and a third is refused.
   task automatic test_drop_oldest_measurement();
      send_item(make_item(MODE_PUSH, KIND_MEASUREMENT, 8'd255, 8'd255, 16'h1111));
      send_item(make_item(MODE_PUSH, KIND_EVENT, 8'd255, 8'd255, 16'h2222));
      send_item(make_item(MODE_PUSH, KIND_ALARM, 8'd255, 8'd255, 16'h3333));
      repeat (2) send_item(random_item(0, 50));
   endtask

   // The measurement is dropped but the space still falls short; the drop stays counted.
   task automatic test_refused_after_drops();
      send_item(make_item(MODE_PUSH, KIND_EVENT, 8'd255, 8'd255, 16'h4444));
      send_item(make_item(MODE_PUSH, KIND_MEASUREMENT, 8'd0, 8'd0, 16'h5555));
      send_item(make_item(MODE_PUSH, KIND_ALARM, 8'd255, 8'd255, 16'h6666));
      repeat (2) send_item(random_item(0, 50));
   endtask

   // Bursts that fill the buffer, mixed ones and bursts that drain it follow in random order.
   task automatic test_random_traffic(input int count, input int send_gap_pct,
                                      input int take_gap_pct);
      int push_pct;
      int meas_pct;
      sender_idle_pct    = send_gap_pct;
      receiver_stall_pct = take_gap_pct;
      push_pct = 60;
      meas_pct = 70;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(2))
               0: push_pct = 90;
               1: push_pct = 60;
               default: push_pct = 25;
            endcase
            meas_pct = $urandom_range(1) ? 70 : 25;
         end
         send_item(random_item(push_pct, meas_pct));
      end
      wait_all_results();
   endtask

   task automatic test_long_backpressure();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_left          = LONG_HOLD;
      repeat (30) send_item(random_item(80, 60));
      wait_all_results();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_pop_on_empty();
      test_kinds_and_extremes();
      test_drop_oldest_measurement();
      test_refused_after_drops();
      wait_all_results();

      test_random_traffic(130, 0, 0);
      test_random_traffic(130, 57, 0);
      test_random_traffic(130, 0, 57);
      test_random_traffic(130, 8, 8);
      test_long_backpressure();

      wait_all_results();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("priority_drop_record_buffer_tb passed");
      end else begin
         $display("priority_drop_record_buffer_tb failed");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+sv
sv/pdrb_pkg.sv
sv/pdrb_mem.sv
sv/pdrb_seq.sv
sv/priority_drop_record_buffer.sv
sv/pdrb_chk.sv
tb/priority_drop_record_buffer_tb.sv
